>>> rtl/awf_pkg.sv
// ----------------------------------------------------------------------------
// awf_pkg
// Shared types and constants of the abbreviation word filter.
// ----------------------------------------------------------------------------
package awf_pkg;

    localparam int MAX_WORD_DEF = 64;
    localparam int QUEUE_DEPTH  = 2;
    localparam int CFG_IDX_W    = 4;
    localparam int CFG_DATA_W   = 64;
    localparam int MASK_W       = 64;

    localparam logic [CFG_IDX_W-1:0] REG_UPPER_0 = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UPPER_1 = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_UPPER_2 = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UPPER_3 = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LOWER_0 = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LOWER_1 = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LOWER_2 = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_LOWER_3 = 4'd7;

    typedef struct packed {
        logic [7:0] data;
        logic       letter;
        logic       upper;
    } t_token;

    typedef enum logic {
        ST_GATHER,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic emitting;
        logic pop;
    } t_back_status;

endpackage

>>> rtl/awf_front.sv
// ----------------------------------------------------------------------------
// awf_front
// Holds the case masks and classifies each accepted byte into a token.
// ----------------------------------------------------------------------------
module awf_front
    import awf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    input  logic [7:0]            i_in_byte,
    input  logic                  i_q_full,
    output logic                  o_push,
    output t_token                o_token
);

    logic [MASK_W-1:0] r_upper [4];
    logic [MASK_W-1:0] r_lower [4];
    logic              up_bit;
    logic              low_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++) begin
                r_upper[k] <= '0;
                r_lower[k] <= '0;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_UPPER_0: r_upper[0] <= i_cfg_data;
                REG_UPPER_1: r_upper[1] <= i_cfg_data;
                REG_UPPER_2: r_upper[2] <= i_cfg_data;
                REG_UPPER_3: r_upper[3] <= i_cfg_data;
                REG_LOWER_0: r_lower[0] <= i_cfg_data;
                REG_LOWER_1: r_lower[1] <= i_cfg_data;
                REG_LOWER_2: r_lower[2] <= i_cfg_data;
                REG_LOWER_3: r_lower[3] <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign up_bit  = r_upper[i_in_byte[7:6]][i_in_byte[5:0]];
    assign low_bit = r_lower[i_in_byte[7:6]][i_in_byte[5:0]];

    assign o_push         = i_in_valid && !i_q_full;
    assign o_token.data   = i_in_byte;
    assign o_token.letter = up_bit || low_bit;
    assign o_token.upper  = up_bit;

endmodule

>>> rtl/awf_queue.sv
// ----------------------------------------------------------------------------
// awf_queue
// Short token queue between the classifying front and the word back end.
// ----------------------------------------------------------------------------
module awf_queue
    import awf_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_token i_token,
    input  logic   i_pop,
    output logic   o_valid,
    output logic   o_full,
    output t_token o_token,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0] o_count
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_token          r_slot [QUEUE_DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic            do_push;
    logic            do_pop;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == CW'(QUEUE_DEPTH));
    assign o_token = r_slot[r_rd_ptr];
    assign o_count = r_count;
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_token;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

>>> rtl/awf_back.sv
// ----------------------------------------------------------------------------
// awf_back
// Gathers letter tokens into the word store, applies the abbreviation rule
// at a delimiter and walks the store out through the output register.
// ----------------------------------------------------------------------------
module awf_back
    import awf_pkg::*;
#(
    parameter int MAX_WORD = MAX_WORD_DEF
)
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_q_valid,
    input  t_token       i_token,
    input  logic         i_out_stall,
    output logic         o_out_valid,
    output logic [7:0]   o_out_byte,
    output logic         o_word_end,
    output t_back_status o_status
);

    localparam int IW = $clog2(MAX_WORD);
    localparam int LW = $clog2(MAX_WORD + 1);
    localparam logic [LW-1:0] MAX_LEN = LW'(MAX_WORD);

    logic [7:0]    r_mem [MAX_WORD];
    t_state        r_state;
    t_state        n_state;
    logic [LW-1:0] r_len;
    logic [LW-1:0] r_ups;
    logic          r_over;
    logic [IW-1:0] r_idx;
    logic          r_rd_valid;
    logic [7:0]    r_rd_data;
    logic          r_rd_last;
    logic          r_out_valid;
    logic [7:0]    r_out_byte;
    logic          r_word_end;

    logic          pop;
    logic          issue;
    logic          move;
    logic          passes;
    logic          rule;
    logic          last;

    always_comb begin
        if (r_len <= LW'(4)) begin
            rule = (r_ups == r_len);
        end else begin
            rule = ({1'b0, r_ups} + (LW+1)'(2)) >= {1'b0, r_len};
        end
    end

    assign passes = !r_over && (r_len > LW'(1)) && rule;
    assign last   = ((LW'(r_idx) + LW'(1)) == r_len);
    assign move   = r_rd_valid && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_GATHER: begin
                if (pop && !i_token.letter && passes) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (issue && last) begin
                    n_state = ST_GATHER;
                end
            end
            default: n_state = ST_GATHER;
        endcase
    end

    always_comb begin
        pop   = 1'b0;
        issue = 1'b0;
        case (r_state)
            ST_GATHER: pop   = i_q_valid;
            ST_EMIT:   issue = !r_rd_valid || move;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (pop && i_token.letter && (r_len < MAX_LEN)) begin
            r_mem[r_len[IW-1:0]] <= i_token.data;
        end
        if (issue) begin
            r_rd_data <= r_mem[r_idx];
            r_rd_last <= last;
        end
        if (move) begin
            r_out_byte <= r_rd_data;
            r_word_end <= r_rd_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_GATHER;
            r_len       <= '0;
            r_ups       <= '0;
            r_over      <= 1'b0;
            r_idx       <= '0;
            r_rd_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rd_valid  <= issue || (r_rd_valid && !move);
            r_out_valid <= move || (r_out_valid && i_out_stall);
            if (pop) begin
                if (i_token.letter) begin
                    if (r_len < MAX_LEN) begin
                        r_len <= r_len + LW'(1);
                        if (i_token.upper) begin
                            r_ups <= r_ups + LW'(1);
                        end
                    end else begin
                        r_over <= 1'b1;
                    end
                end else if (!passes) begin
                    r_len  <= '0;
                    r_ups  <= '0;
                    r_over <= 1'b0;
                end
            end
            if (issue) begin
                if (last) begin
                    r_idx  <= '0;
                    r_len  <= '0;
                    r_ups  <= '0;
                    r_over <= 1'b0;
                end else begin
                    r_idx <= r_idx + IW'(1);
                end
            end
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_out_byte        = r_out_byte;
    assign o_word_end        = r_word_end;
    assign o_status.emitting = (r_state == ST_EMIT);
    assign o_status.pop      = pop;

endmodule

>>> rtl/abbreviation_word_filter.sv
// ----------------------------------------------------------------------------
// abbreviation_word_filter
// Classifies text bytes with configurable case masks and passes on only the
// words that look like abbreviations, one byte per item.
// ----------------------------------------------------------------------------
//   channel | direction | handshake               | payload
//   input   | in        | i_in_valid / o_in_stall | i_in_byte
//   output  | out       | o_out_valid/i_out_stall | o_out_byte, o_word_end
//   config  | in        | i_cfg_we                | i_cfg_index, i_cfg_data
//
// Bytes are taken one per cycle while the back end gathers a word.
// An accepted word holds the back end while its store is read out, one
// store read per cycle unless the output stalls; the two-entry token queue
// absorbs input meanwhile, then stalls it.
// Reset is synchronous and clears all masks, counters and queue state.
// A stalled output holds its byte while the read pipeline waits behind it.
// ----------------------------------------------------------------------------
module abbreviation_word_filter
    import awf_pkg::*;
#(
    parameter int MAX_WORD = MAX_WORD_DEF
)
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [7:0]            i_in_byte,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [7:0]            o_out_byte,
    output logic                  o_word_end
);

    logic         push;
    t_token       front_token;
    logic         q_valid;
    logic         q_full;
    t_token       q_token;
    logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count;
    t_back_status back_status;

    assign o_in_stall = q_full;

    awf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .i_in_byte   (i_in_byte),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_token     (front_token)
    );

    awf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_token (front_token),
        .i_pop   (back_status.pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_token (q_token),
        .o_count (q_count)
    );

    awf_back #(
        .MAX_WORD (MAX_WORD)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_token     (q_token),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_byte  (o_out_byte),
        .o_word_end  (o_word_end),
        .o_status    (back_status)
    );

    a_queue_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_count <= ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH))
        else $error("token queue holds more than its depth");

    a_no_pop_while_emit : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(back_status.emitting && back_status.pop))
        else $error("queue popped while a word is being emitted");

    a_reset_idle : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

endmodule
